// ===== hdl/abn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abn_pkg;

  // Depth of the ranking; the output ports name exactly three slots.
  localparam int unsigned RankDepth = 3;
  localparam int unsigned CountBits = 32;

  // Program counter of the microcode sequencer.
  localparam int unsigned StepBits = 3;

  typedef logic [StepBits-1:0] step_t;

  localparam step_t StepIdle    = 3'd0;
  localparam step_t StepTest    = 3'd1;
  localparam step_t StepDiv     = 3'd2;
  localparam step_t StepAddI    = 3'd3;
  localparam step_t StepAddQ    = 3'd4;
  localparam step_t StepSubN    = 3'd5;
  localparam step_t StepUpdate  = 3'd6;
  localparam step_t StepPublish = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_TEST    = 3'd1,
    OP_DIV     = 3'd2,
    OP_ADD_I   = 3'd3,
    OP_ADD_Q   = 3'd4,
    OP_SUB_N   = 3'd5,
    OP_UPDATE  = 3'd6,
    OP_PUBLISH = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_IN_IDLE  = 3'd2,
    COND_SQ_GT_N  = 3'd3,
    COND_CNT_NZ   = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_idle;
    logic sq_gt_n;
    logic cnt_nz;
    logic out_busy;
  } status_t;

  // The program. When the condition holds the sequencer jumps to target,
  // otherwise it steps to the next word.
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    unique case (step)
      StepIdle:    w = '{op: OP_LOAD,    cond: COND_IN_IDLE,  target: StepIdle};
      StepTest:    w = '{op: OP_TEST,    cond: COND_SQ_GT_N,  target: StepSubN};
      StepDiv:     w = '{op: OP_DIV,     cond: COND_CNT_NZ,   target: StepDiv};
      StepAddI:    w = '{op: OP_ADD_I,   cond: COND_NEVER,    target: StepIdle};
      StepAddQ:    w = '{op: OP_ADD_Q,   cond: COND_ALWAYS,   target: StepTest};
      StepSubN:    w = '{op: OP_SUB_N,   cond: COND_NEVER,    target: StepIdle};
      StepUpdate:  w = '{op: OP_UPDATE,  cond: COND_NEVER,    target: StepIdle};
      StepPublish: w = '{op: OP_PUBLISH, cond: COND_OUT_BUSY, target: StepPublish};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/abn_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abn_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire abn_pkg::status_t status_i,
  output abn_pkg::uword_t       uword_o
);
  import abn_pkg::*;

  step_t  pc_q, pc_d;
  uword_t uword;
  logic   take;

  assign uword = ucode_rom(pc_q);

  always_comb begin
    unique case (uword.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_IN_IDLE:  take = status_i.in_idle;
      COND_SQ_GT_N:  take = status_i.sq_gt_n;
      COND_CNT_NZ:   take = status_i.cnt_nz;
      COND_OUT_BUSY: take = status_i.out_busy;
      default:       take = 1'b0;
    endcase
    pc_d = take ? uword.target : step_t'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uword;

endmodule

`default_nettype wire

// ===== hdl/abn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abn_dp #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire abn_pkg::op_e          op_i,
  input  wire logic                  load_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       sq_gt_n_o,
  output logic                       cnt_nz_o,
  output logic                       abundant_o,
  output logic [VALUE_BITS-1:0]      num_o,
  output logic [VALUE_BITS+2:0]      sum_o
);
  import abn_pkg::*;

  localparam int unsigned SumBits = VALUE_BITS + 3;
  localparam int unsigned SqBits  = VALUE_BITS + 2;
  localparam int unsigned IBits   = (VALUE_BITS + 1) / 2 + 1;
  localparam int unsigned CntBits = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [IBits-1:0]      i_q, i_d;
  logic [SqBits-1:0]     sq_q, sq_d;
  logic [SumBits-1:0]    acc_q, acc_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   i_wide;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;
  logic                  divides;

  // One restoring division step: shift in the next dividend bit and
  // subtract the divisor when it fits.
  assign trial   = {rem_q, quo_q[VALUE_BITS-1]};
  assign i_wide  = (VALUE_BITS+1)'(i_q);
  assign fits    = trial >= i_wide;
  assign diff    = trial - i_wide;
  assign divides = (rem_q == '0);

  always_comb begin
    n_d   = n_q;
    i_d   = i_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    unique case (op_i)
      OP_LOAD: begin
        if (load_i) begin
          n_d   = value_i;
          i_d   = IBits'(1);
          sq_d  = SqBits'(1);
          acc_d = '0;
        end
      end
      OP_TEST: begin
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CntBits'(VALUE_BITS - 1);
      end
      OP_DIV: begin
        rem_d = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], fits};
        cnt_d = cnt_q - 1'b1;
      end
      OP_ADD_I: begin
        if (divides) begin
          acc_d = acc_q + SumBits'(i_q);
        end
      end
      OP_ADD_Q: begin
        // The cofactor counts once more unless it equals the divisor.
        if (divides && (quo_q != VALUE_BITS'(i_q))) begin
          acc_d = acc_q + SumBits'(quo_q);
        end
        i_d  = i_q + 1'b1;
        sq_d = sq_q + SqBits'({i_q, 1'b1});
      end
      OP_SUB_N: begin
        acc_d = acc_q - SumBits'(n_q);
      end
      OP_UPDATE, OP_PUBLISH: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      i_q   <= '0;
      sq_q  <= '0;
      acc_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else begin
      n_q   <= n_d;
      i_q   <= i_d;
      sq_q  <= sq_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_d;
    end
  end

  assign sq_gt_n_o  = sq_q > SqBits'(n_q);
  assign cnt_nz_o   = (cnt_q != '0);
  assign abundant_o = acc_q > SumBits'(n_q);
  assign num_o      = n_q;
  assign sum_o      = acc_q;

endmodule

`default_nettype wire

// ===== hdl/abn_rank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abn_rank #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     update_i,
  input  wire logic [VALUE_BITS-1:0]    num_i,
  input  wire logic [VALUE_BITS+2:0]    sum_i,
  output logic [abn_pkg::CountBits-1:0] count_o,
  output logic [VALUE_BITS-1:0]         nums_o [abn_pkg::RankDepth],
  output logic [VALUE_BITS+2:0]         sums_o [abn_pkg::RankDepth]
);
  import abn_pkg::*;

  logic [CountBits-1:0]  count_q, count_d;
  logic [VALUE_BITS-1:0] nums_q [RankDepth];
  logic [VALUE_BITS-1:0] nums_d [RankDepth];
  logic [VALUE_BITS+2:0] sums_q [RankDepth];
  logic [VALUE_BITS+2:0] sums_d [RankDepth];

  // The new pair lands at the first slot with a strictly smaller sum and
  // pushes the slots below it down by one; the last one drops out.
  always_comb begin
    logic                  placed;
    logic [VALUE_BITS-1:0] carry_num;
    logic [VALUE_BITS+2:0] carry_sum;
    placed    = 1'b0;
    carry_num = '0;
    carry_sum = '0;
    count_d   = count_q;
    for (int k = 0; k < RankDepth; k++) begin
      nums_d[k] = nums_q[k];
      sums_d[k] = sums_q[k];
    end
    if (update_i) begin
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
      for (int k = 0; k < RankDepth; k++) begin
        if (placed) begin
          nums_d[k] = carry_num;
          sums_d[k] = carry_sum;
        end else if (sum_i > sums_q[k]) begin
          nums_d[k] = num_i;
          sums_d[k] = sum_i;
          placed    = 1'b1;
        end
        carry_num = nums_q[k];
        carry_sum = sums_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < RankDepth; k++) begin
        nums_q[k] <= '0;
        sums_q[k] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int k = 0; k < RankDepth; k++) begin
        nums_q[k] <= nums_d[k];
        sums_q[k] <= sums_d[k];
      end
    end
  end

  assign count_o = count_q;
  assign nums_o  = nums_q;
  assign sums_o  = sums_q;

endmodule

`default_nettype wire

// ===== hdl/abundant_number_top_three.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   value_i
// out       output     out_valid_o/out_ready_i abundant_count_o, first/second/third
//                                              number and sum
//
// Each item runs a microcoded trial division: for every i with i*i <= value,
// a test, a restoring divide and the adds of i and its cofactor, then the closing
// test, subtract, rank, publish and load.
// Reset clears the count and the ranking to zero at once.
// A stalled output holds the result; the next item still starts and waits only at publish.
module abundant_number_top_three #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [VALUE_BITS-1:0]    value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [abn_pkg::CountBits-1:0] abundant_count_o,
  output logic [VALUE_BITS-1:0]         first_number_o,
  output logic [VALUE_BITS+2:0]         first_sum_o,
  output logic [VALUE_BITS-1:0]         second_number_o,
  output logic [VALUE_BITS+2:0]         second_sum_o,
  output logic [VALUE_BITS-1:0]         third_number_o,
  output logic [VALUE_BITS+2:0]         third_sum_o
);
  import abn_pkg::*;

  uword_t                uword;
  status_t               status;
  logic                  sq_gt_n;
  logic                  cnt_nz;
  logic                  abundant;
  logic [VALUE_BITS-1:0] num;
  logic [VALUE_BITS+2:0] sum;
  logic [CountBits-1:0]  count;
  logic [VALUE_BITS-1:0] nums [RankDepth];
  logic [VALUE_BITS+2:0] sums [RankDepth];

  logic                  out_valid_q, out_valid_d;
  logic [CountBits-1:0]  out_count_q;
  logic [VALUE_BITS-1:0] out_nums_q [RankDepth];
  logic [VALUE_BITS+2:0] out_sums_q [RankDepth];
  logic                  out_busy;
  logic                  publish;

  assign in_ready_o = (uword.op == OP_LOAD);
  assign out_busy   = out_valid_q && !out_ready_i;
  assign publish    = (uword.op == OP_PUBLISH) && !out_busy;

  assign status = '{in_idle:  !in_valid_i,
                    sq_gt_n:  sq_gt_n,
                    cnt_nz:   cnt_nz,
                    out_busy: out_busy};

  abn_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  abn_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (uword.op),
    .load_i     (in_valid_i),
    .value_i    (value_i),
    .sq_gt_n_o  (sq_gt_n),
    .cnt_nz_o   (cnt_nz),
    .abundant_o (abundant),
    .num_o      (num),
    .sum_o      (sum)
  );

  abn_rank #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i ((uword.op == OP_UPDATE) && abundant),
    .num_i    (num),
    .sum_i    (sum),
    .count_o  (count),
    .nums_o   (nums),
    .sums_o   (sums)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      out_count_q <= count;
      for (int k = 0; k < RankDepth; k++) begin
        out_nums_q[k] <= nums[k];
        out_sums_q[k] <= sums[k];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign abundant_count_o = out_count_q;
  assign first_number_o   = out_nums_q[0];
  assign first_sum_o      = out_sums_q[0];
  assign second_number_o  = out_nums_q[1];
  assign second_sum_o     = out_sums_q[1];
  assign third_number_o   = out_nums_q[2];
  assign third_sum_o      = out_sums_q[2];

endmodule

`default_nettype wire
